// ===== hdl/ttl_pkg.sv =====
// ----------------------------------------------------------------------------
// ttl_pkg
// Shared types and codes for the token table: commands, status codes and the
// scan token that walks the row of entry cells.
// ----------------------------------------------------------------------------
package ttl_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;
    typedef logic [6:0] count_t;

    localparam cmd_t CMD_GENERATE = 2'd0;
    localparam cmd_t CMD_RENEW    = 2'd1;
    localparam cmd_t CMD_COUNT    = 2'd2;

    localparam status_t STATUS_DONE   = 2'd0;
    localparam status_t STATUS_FULL   = 2'd1;
    localparam status_t STATUS_ABSENT = 2'd2;

    localparam count_t COUNT_MAX = 7'd127;

    typedef struct packed {
        logic   valid;
        cmd_t   cmd;
        logic   match;
        logic   free_found;
        count_t count;
    } token_t;

endpackage

// ===== hdl/ttl_token_table_top.sv =====
// ----------------------------------------------------------------------------
// ttl_token_table_top
// Keyed table of tokens with expiry times: generate, renew and count.
// ----------------------------------------------------------------------------
// A request is taken when s_valid and s_ready are high. A scan token walks
// the row of ENTRIES entry cells, one cell per cycle, and a generate that
// needs a new slot writes it in the cycle the token leaves the last cell.
// s_ready rises again with m_valid. One request is in the table at a time;
// a finished result sits in the output register while the next request is
// taken. The user writes time_to_live through the cfg port only while no
// request is in progress; the block does not enforce this. It resets to 1.
module ttl_token_table_top #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [63:0] s_token_key,
    input  logic [31:0] s_current_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [6:0]  m_live_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t              state_reg;
    logic [31:0]         ttl_reg;
    logic [KEY_BITS-1:0] req_key_reg;
    logic [31:0]         req_now_reg;
    logic [32:0]         req_expiry_reg;
    ttl_pkg::token_t     launch_reg;
    ttl_pkg::status_t    res_status_reg, res_status_next;
    ttl_pkg::count_t     res_count_reg, res_count_next;
    logic                m_valid_reg;
    ttl_pkg::status_t    m_status_reg;
    ttl_pkg::count_t     m_count_reg;

    ttl_pkg::token_t     tok [ENTRIES+1];
    ttl_pkg::token_t     tok_end;
    logic                commit;

    assign tok[0]  = launch_reg;
    assign tok_end = tok[ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            ttl_cell #(
                .KEY_BITS(KEY_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .tok_in    (tok[gi]),
                .tok_out   (tok[gi+1]),
                .req_key   (req_key_reg),
                .req_now   (req_now_reg),
                .req_expiry(req_expiry_reg),
                .commit    (commit)
            );
        end
    endgenerate

    assign commit = tok_end.valid && (tok_end.cmd == ttl_pkg::CMD_GENERATE) &&
                    !tok_end.match && tok_end.free_found;

    always_comb begin
        res_status_next = ttl_pkg::STATUS_DONE;
        res_count_next  = '0;
        case (tok_end.cmd)
            ttl_pkg::CMD_GENERATE: begin
                if (!tok_end.match && !tok_end.free_found) begin
                    res_status_next = ttl_pkg::STATUS_FULL;
                end
            end
            ttl_pkg::CMD_RENEW: begin
                if (!tok_end.match) begin
                    res_status_next = ttl_pkg::STATUS_ABSENT;
                end
            end
            ttl_pkg::CMD_COUNT: begin
                res_count_next = tok_end.count;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ttl_reg     <= 32'd1;
            launch_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                ttl_reg <= cfg_data;
            end
            if (state_reg == ST_RESULT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        launch_reg <= '{valid: 1'b1, cmd: s_command, match: 1'b0,
                                        free_found: 1'b0, count: '0};
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    launch_reg.valid <= 1'b0;
                    if (tok_end.valid) begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_status_reg <= res_status_reg;
                        m_count_reg  <= res_count_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            req_key_reg    <= s_token_key[KEY_BITS-1:0];
            req_now_reg    <= s_current_time;
            req_expiry_reg <= {1'b0, s_current_time} + {1'b0, ttl_reg};
        end
        if (state_reg == ST_SCAN && tok_end.valid) begin
            res_status_reg <= res_status_next;
            res_count_reg  <= res_count_next;
        end
    end

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_live_count = m_count_reg;

endmodule

// ===== hdl/ttl_cell.sv =====
// ----------------------------------------------------------------------------
// ttl_cell
// One table entry. Updates its entry as the scan token passes and forwards the
// token to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module ttl_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ttl_pkg::token_t     tok_in,
    output ttl_pkg::token_t     tok_out,
    input  logic [KEY_BITS-1:0] req_key,
    input  logic [31:0]         req_now,
    input  logic [32:0]         req_expiry,
    input  logic                commit
);

    logic                valid_reg, valid_next;
    logic                cand_reg, cand_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [32:0]         expiry_reg, expiry_next;
    ttl_pkg::token_t     tok_reg, tok_next;

    logic hit;
    logic expired;

    assign hit     = valid_reg && (key_reg == req_key);
    assign expired = expiry_reg <= {1'b0, req_now};

    always_comb begin
        valid_next  = valid_reg;
        cand_next   = cand_reg;
        key_next    = key_reg;
        expiry_next = expiry_reg;
        tok_next    = tok_in;
        if (tok_in.valid) begin
            case (tok_in.cmd)
                ttl_pkg::CMD_GENERATE: begin
                    if (hit) begin
                        expiry_next    = req_expiry;
                        tok_next.match = 1'b1;
                    end
                    cand_next = !tok_in.free_found && (!valid_reg || expired);
                    if (cand_next) begin
                        tok_next.free_found = 1'b1;
                    end
                end
                ttl_pkg::CMD_RENEW: begin
                    if (hit && !expired) begin
                        expiry_next    = req_expiry;
                        tok_next.match = 1'b1;
                    end
                end
                ttl_pkg::CMD_COUNT: begin
                    if (valid_reg && expired) begin
                        valid_next = 1'b0;
                    end else if (valid_reg && (tok_in.count < ttl_pkg::COUNT_MAX)) begin
                        tok_next.count = tok_in.count + 7'd1;
                    end
                end
                default: ;
            endcase
        end
        if (commit && cand_reg) begin
            valid_next  = 1'b1;
            key_next    = req_key;
            expiry_next = req_expiry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cand_reg  <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        expiry_reg <= expiry_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== hdl/ttl_checker.sv =====
// ----------------------------------------------------------------------------
// ttl_checker
// Port-level checks for the token table, bound to the top level.
// ----------------------------------------------------------------------------
module ttl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_command,
    input logic [63:0] s_token_key,
    input logic [31:0] s_current_time,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [6:0]  m_live_count
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_live_count))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_command) &&
                                $stable(s_token_key) && $stable(s_current_time))
        else $error("request changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ttl_pkg::STATUS_DONE) ||
                    (m_status == ttl_pkg::STATUS_FULL) ||
                    (m_status == ttl_pkg::STATUS_ABSENT))
        else $error("unknown status code");

    a_count_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ttl_pkg::STATUS_DONE) |-> m_live_count == 7'd0)
        else $error("nonzero count on a failed request");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken during a scan");

endmodule

bind ttl_token_table_top ttl_checker u_ttl_checker (.*);

// ===== sim/tb_ttl_token_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ttl_token_table_top
// Self-checking bench for the token table. A driver feeds requests from a
// queue, a local table mirrors slot state to predict each status and live
// count, and a monitor compares every result transfer in order. Directed
// corner cases come first, then randomized phases with several lifetimes,
// key pools and time patterns under changing handshake back-pressure.
// ----------------------------------------------------------------------------
module tb_ttl_token_table_top;

    localparam int            ENTRIES   = 64;
    localparam int            WDOG_MAX  = 4000;
    localparam int            POOL_SIZE = 128;
    localparam ttl_pkg::cmd_t CMD_NOP   = 2'd3;

    typedef struct packed {
        ttl_pkg::cmd_t cmd;
        logic [63:0]   key;
        logic [31:0]   ts;
    } request_t;

    typedef struct packed {
        ttl_pkg::status_t status;
        ttl_pkg::count_t  live_count;
    } outcome_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data       = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command      = '0;
    logic [63:0] s_token_key    = '0;
    logic [31:0] s_current_time = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [1:0]  m_status;
    logic [6:0]  m_live_count;

    ttl_token_table_top #(
        .ENTRIES (ENTRIES),
        .KEY_BITS(64)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_token_key   (s_token_key),
        .s_current_time(s_current_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_live_count  (m_live_count)
    );

    always #5 aclk = ~aclk;

    // mirror of the table
    logic [31:0] lifetime = 32'd1;
    logic        slot_used   [ENTRIES];
    logic [63:0] slot_key    [ENTRIES];
    logic [32:0] slot_expiry [ENTRIES];

    request_t    request_q [$];
    outcome_t    awaited_results [$];
    logic [63:0] key_pool [POOL_SIZE];
    logic [31:0] now_ts = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int wdog_cnt      = 0;
    int errors        = 0;
    int n_items       = 0;
    int n_results     = 0;
    int n_full        = 0;
    int n_absent      = 0;
    int n_counts      = 0;
    int peak_live     = 0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            slot_used[i]   = 1'b0;
            slot_key[i]    = '0;
            slot_expiry[i] = '0;
        end
    end

    function automatic int lookup_key(logic [63:0] key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic outcome_t table_apply(ttl_pkg::cmd_t cmd, logic [63:0] key,
                                             logic [31:0] now);
        outcome_t    r;
        int          slot;
        logic [32:0] new_expiry;
        logic [32:0] now_x;
        r.status     = ttl_pkg::STATUS_DONE;
        r.live_count = '0;
        now_x        = {1'b0, now};
        new_expiry   = now_x + {1'b0, lifetime};
        case (cmd)
            ttl_pkg::CMD_GENERATE: begin
                slot = lookup_key(key);
                if (slot < 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!slot_used[i] || slot_expiry[i] <= now_x) begin
                            slot = i;
                            break;
                        end
                    end
                end
                if (slot < 0) begin
                    r.status = ttl_pkg::STATUS_FULL;
                end else begin
                    slot_used[slot]   = 1'b1;
                    slot_key[slot]    = key;
                    slot_expiry[slot] = new_expiry;
                end
            end
            ttl_pkg::CMD_RENEW: begin
                slot = lookup_key(key);
                if (slot >= 0 && slot_expiry[slot] > now_x)
                    slot_expiry[slot] = new_expiry;
                else
                    r.status = ttl_pkg::STATUS_ABSENT;
            end
            ttl_pkg::CMD_COUNT: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_used[i] && slot_expiry[i] <= now_x)
                        slot_used[i] = 1'b0;
                    if (slot_used[i] && r.live_count != ttl_pkg::COUNT_MAX)
                        r.live_count = r.live_count + 7'd1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // request driver
    always @(posedge aclk) begin : drv
        request_t req;
        outcome_t res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                res = table_apply(s_command, s_token_key, s_current_time);
                awaited_results = {awaited_results, res};
                n_items++;
                if (res.status == ttl_pkg::STATUS_FULL)
                    n_full++;
                if (res.status == ttl_pkg::STATUS_ABSENT)
                    n_absent++;
                if (s_command == ttl_pkg::CMD_COUNT) begin
                    n_counts++;
                    if (res.live_count > peak_live)
                        peak_live = res.live_count;
                end
            end
            if (s_valid && !s_ready) begin
                // hold the current transfer
            end else if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = request_q.pop_front();
                s_valid        <= 1'b1;
                s_command      <= req.cmd;
                s_token_key    <= req.key;
                s_current_time <= req.ts;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : mon
        outcome_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: status %0d live_count %0d",
                           m_status, m_live_count);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        errors++;
                    end
                    if (m_live_count !== want.live_count) begin
                        $error("live_count: expected %0d, got %0d",
                               want.live_count, m_live_count);
                        errors++;
                    end
                end
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // no-progress watchdog
    always @(posedge aclk) begin : wdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            wdog_cnt <= 0;
        end else begin
            wdog_cnt <= wdog_cnt + 1;
            if (wdog_cnt == WDOG_MAX) begin
                $display("ttl_token_table_top test failed");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (request_q.size() != 0 || s_valid || awaited_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_lifetime(logic [31:0] v);
        wait_idle();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge aclk);
        while (!cfg_ready);
        lifetime = v;
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic push_req(ttl_pkg::cmd_t cmd, logic [63:0] key, logic [31:0] ts);
        request_t r;
        r.cmd = cmd;
        r.key = key;
        r.ts  = ts;
        request_q = {request_q, r};
    endtask

    task automatic queue_random(int n, int pool_n, int unsigned step);
        request_t r;
        int       pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 45)
                r.cmd = ttl_pkg::CMD_GENERATE;
            else if (pick < 75)
                r.cmd = ttl_pkg::CMD_RENEW;
            else if (pick < 95)
                r.cmd = ttl_pkg::CMD_COUNT;
            else
                r.cmd = CMD_NOP;
            if ($urandom_range(19) == 0)
                r.key = {$urandom, $urandom};
            else
                r.key = key_pool[$urandom_range(pool_n - 1)];
            case ($urandom_range(49))
                0:       now_ts = $urandom;
                1:       now_ts = now_ts - $urandom_range(step * 20);
                default: now_ts = now_ts + $urandom_range(step);
            endcase
            r.ts = now_ts;
            request_q = {request_q, r};
        end
    endtask

    task automatic run_phase(logic [31:0] ttl_val, int n, int pool_n, int unsigned step);
        write_lifetime(ttl_val);
        queue_random(n, pool_n, step);
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 28;
        recv_idle_pct = 51;

        // directed: reset lifetime of one tick
        push_req(ttl_pkg::CMD_COUNT,    64'd0, 32'd0);
        push_req(ttl_pkg::CMD_RENEW,    64'd0, 32'd5);
        push_req(ttl_pkg::CMD_GENERATE, 64'd0, 32'd10);
        push_req(ttl_pkg::CMD_GENERATE, '1,    32'd10);
        push_req(ttl_pkg::CMD_RENEW,    64'd0, 32'd10);
        push_req(ttl_pkg::CMD_COUNT,    64'd0, 32'd10);
        push_req(ttl_pkg::CMD_RENEW,    64'd0, 32'd11);
        push_req(ttl_pkg::CMD_GENERATE, 64'd0, 32'd20);
        push_req(CMD_NOP,               {$urandom, $urandom}, '1);
        push_req(ttl_pkg::CMD_COUNT,    '1,    '1);

        // largest lifetime, wrap past 32 bits, time going backwards
        write_lifetime('1);
        push_req(ttl_pkg::CMD_GENERATE, 64'h5555_5555_5555_5555, '1);
        push_req(ttl_pkg::CMD_RENEW,    64'h5555_5555_5555_5555, 32'd0);
        push_req(ttl_pkg::CMD_COUNT,    64'd0, 32'hFFFF_FFFE);
        push_req(ttl_pkg::CMD_GENERATE, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
        push_req(ttl_pkg::CMD_COUNT,    64'd0, 32'hFFFF_FFFF);

        // zero lifetime: entries expire on arrival
        write_lifetime(32'd0);
        push_req(ttl_pkg::CMD_GENERATE, key_pool[2], 32'd100);
        push_req(ttl_pkg::CMD_RENEW,    key_pool[2], 32'd100);
        push_req(ttl_pkg::CMD_GENERATE, key_pool[3], 32'd100);
        push_req(ttl_pkg::CMD_COUNT,    64'd0, 32'h7FFF_FFFF);

        now_ts = 32'd1000;
        run_phase(32'd1,  150, 8,  2);
        run_phase(32'd50, 220, 40, 3);

        wait_idle();
        send_idle_pct = 51;
        recv_idle_pct = 28;
        run_phase(32'd2_000_000,   250, 96, 5);
        run_phase(32'h8000_0000,   200, 70, 32'h0800_0000);

        // back-pressure: long receiver stall, then sender waits for a full drain
        write_lifetime(32'd300);
        queue_random(125, 64, 10);
        hold_request = 300;
        wait_idle();
        queue_random(125, 64, 10);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(32'd20,   250, 16, 4);
        run_phase(32'd5000, 230, 80, 50);

        wait_idle();
        repeat (ENTRIES + 8) @(posedge aclk);

        $display("covered %0d requests, %0d results: %0d table-full drops, %0d renew misses",
                 n_items, n_results, n_full, n_absent);
        $display("%0d count requests, peak live count %0d, %0d mismatches",
                 n_counts, peak_live, errors);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("ttl_token_table_top test passed");
        end else begin
            $display("ttl_token_table_top test failed");
        end
        $finish;
    end

endmodule
